/* rtl/png_sf_pkg.sv */
// shared constants and types for the png scanline filter
package png_sf_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 13;
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = PIX_W / CH_W;
    localparam int FILT_W    = 3;
    localparam int USER_W    = FILT_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE = 1'b1;

    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

    typedef struct packed {
        logic              first_col;
        logic              first_row;
        logic [FILT_W-1:0] filter;
    } s1_ctrl_t;

endpackage

/* rtl/png_sf_linebuf.sv */
// previous-row line store, one read-first port
module png_sf_linebuf
    import png_sf_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [COL_W-1:0] addr,
    input  logic [PIX_W-1:0] wr_data,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/png_sf_lane.sv */
// one channel lane: predictor and modulo-256 difference
module png_sf_lane
    import png_sf_pkg::*;
(
    input  logic [FILT_W-1:0] filter,
    input  logic [CH_W-1:0]   x,
    input  logic [CH_W-1:0]   a,
    input  logic [CH_W-1:0]   b,
    input  logic [CH_W-1:0]   c,
    output logic [CH_W-1:0]   res
);

    logic signed [CH_W+1:0] dbc;
    logic signed [CH_W+1:0] dac;
    logic signed [CH_W+1:0] dsum;
    logic [CH_W+1:0]        pa;
    logic [CH_W+1:0]        pb;
    logic [CH_W+1:0]        pc;
    logic [CH_W:0]          sum_ab;
    logic [CH_W-1:0]        paeth;
    logic [CH_W-1:0]        pred;

    always_comb
    begin
        dbc    = $signed({2'b00, b}) - $signed({2'b00, c});
        dac    = $signed({2'b00, a}) - $signed({2'b00, c});
        dsum   = dbc + dac;
        pa     = dbc[CH_W+1] ? (CH_W+2)'(-dbc) : dbc;
        pb     = dac[CH_W+1] ? (CH_W+2)'(-dac) : dac;
        pc     = dsum[CH_W+1] ? (CH_W+2)'(-dsum) : dsum;
        sum_ab = {1'b0, a} + {1'b0, b};

        if (pa <= pb && pa <= pc)
            paeth = a;
        else if (pb <= pc)
            paeth = b;
        else
            paeth = c;

        case (filter)
            FILT_NONE: pred = '0;
            FILT_SUB:  pred = a;
            FILT_UP:   pred = b;
            FILT_AVG:  pred = sum_ab[CH_W:1];
            default:   pred = paeth;
        endcase

        res = x - pred;
    end

endmodule

/* rtl/png_scanline_filter.sv */
// png scanline filter top level: control, line store, channel lanes, output register
//
// Filters one RGBA pixel per clock, unless m_tready stalls the output, with
// PNG None, Sub, Up, Average or Paeth. The filter type is taken from the first
// pixel of each line (values above four act as Paeth) and tagged on every output
// word; line_start marks the first pixel of a line. When a pixel is accepted, the
// previous-row store is read into a register and the pixel is held in stage one;
// the lanes then feed the output register once it is free. Back-to-back pixels
// stream at one per clock unless the output stalls; the line store is a single
// read-first port that reads and writes the same column per pixel. Lines
// longer than 4096 pixels are cut to 4096, a width of zero acts as one.
// Configuration must be written only while no pixel is in flight; raising the
// width between rows of a frame reads unwritten store entries.
module png_scanline_filter
    import png_sf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,  // red, green, blue, alpha
    input  logic [USER_W-1:0]    s_tuser,  // filter_type, frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic [USER_W-1:0]    m_tuser   // type_tag, line_start
);

    logic [WIDTH_W-1:0] width_reg;
    logic               alpha_en_reg;
    logic [COL_W-1:0]   col_reg;
    logic               first_row_reg;
    logic [FILT_W-1:0]  line_filter_reg;

    logic               s1_valid_reg;
    s1_ctrl_t           s1_ctrl_reg;
    logic [PIX_W-1:0]   s1_cur_reg;
    logic [PIX_W-1:0]   left_reg;
    logic [PIX_W-1:0]   ul_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic [USER_W-1:0]  out_user_reg;

    logic               accept;
    logic               s1_fire;
    logic               out_free;
    logic               frame;
    logic [COL_W-1:0]   col;
    logic               first_row;
    logic               first_col;
    logic [FILT_W-1:0]  filt_in;
    logic [FILT_W-1:0]  filter;
    logic [WIDTH_W-1:0] width_eff;
    logic [WIDTH_W-1:0] col_inc;
    logic               last_col;
    s1_ctrl_t           ctrl_next;

    logic [PIX_W-1:0]   mem_rd;
    logic [PIX_W-1:0]   above;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   upleft;
    logic [PIX_W-1:0]   res;
    logic [PIX_W-1:0]   data_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            alpha_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg    <= cfg_data;
                REG_ALPHA_ENABLE: alpha_en_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // position and line filter
    always_comb
    begin
        frame     = s_tuser[FILT_W];
        filt_in   = s_tuser[FILT_W-1:0];
        col       = frame ? '0 : col_reg;
        first_row = frame || first_row_reg;
        first_col = (col == '0);
        if (!first_col)
            filter = line_filter_reg;
        else if (filt_in > FILT_PAETH)
            filter = FILT_PAETH;
        else
            filter = filt_in;

        if (width_reg == '0)
            width_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;

        col_inc  = {{(WIDTH_W-COL_W){1'b0}}, col} + WIDTH_W'(1);
        last_col = (col_inc >= width_eff);

        ctrl_next.first_col = first_col;
        ctrl_next.first_row = first_row;
        ctrl_next.filter    = filter;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            first_row_reg   <= 1'b1;
            line_filter_reg <= FILT_NONE;
        end
        else if (accept)
        begin
            col_reg         <= last_col ? '0 : col_inc[COL_W-1:0];
            first_row_reg   <= last_col ? 1'b0 : first_row;
            line_filter_reg <= filter;
        end
    end

    png_sf_linebuf u_linebuf (
        .clk     (clk),
        .en      (accept),
        .addr    (col),
        .wr_data (s_tdata),
        .rd_data (mem_rd)
    );

    // stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= ctrl_next;
            s1_cur_reg  <= s_tdata;
        end
        if (s1_fire)
        begin
            left_reg <= s1_cur_reg;
            ul_reg   <= above;
        end
    end

    always_comb
    begin
        above  = s1_ctrl_reg.first_row ? '0 : mem_rd;
        left   = s1_ctrl_reg.first_col ? '0 : left_reg;
        upleft = (s1_ctrl_reg.first_col || s1_ctrl_reg.first_row) ? '0 : ul_reg;
    end

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        png_sf_lane u_lane (
            .filter (s1_ctrl_reg.filter),
            .x      (s1_cur_reg[i*CH_W +: CH_W]),
            .a      (left[i*CH_W +: CH_W]),
            .b      (above[i*CH_W +: CH_W]),
            .c      (upleft[i*CH_W +: CH_W]),
            .res    (res[i*CH_W +: CH_W])
        );
    end

    // merge lanes, mask alpha
    always_comb
    begin
        data_next = res;
        if (!alpha_en_reg)
            data_next[PIX_W-1 -: CH_W] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= data_next;
            out_user_reg <= {s1_ctrl_reg.first_col, s1_ctrl_reg.filter};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* tb/png_scanline_filter_tb.sv */
// self-checking testbench for the png scanline filter with a pixel scoreboard
module png_scanline_filter_tb;
    import png_sf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 11;

    typedef struct packed {
        logic [USER_W-1:0] user;
        logic [PIX_W-1:0]  data;
    } word_t;

    class filter_scoreboard;
        logic [PIX_W-1:0]   row_store [MAX_WIDTH];
        logic [PIX_W-1:0]   left_pix;
        logic [PIX_W-1:0]   upleft_pix;
        int unsigned        column;
        bit                 first_row;
        logic [FILT_W-1:0]  line_filt;
        logic [WIDTH_W-1:0] width_reg;
        bit                 alpha_on;
        word_t              pending_words [$];
        int                 errors;
        int                 words_checked;
        int                 line_count;
        int                 filter_lines [5];

        function new();
            left_pix = '0;
            upleft_pix = '0;
            column = 0;
            first_row = 1'b1;
            line_filt = FILT_NONE;
            width_reg = WIDTH_RESET;
            alpha_on = 1'b0;
            errors = 0;
            words_checked = 0;
            line_count = 0;
            foreach (filter_lines[k])
                filter_lines[k] = 0;
            foreach (row_store[k])
                row_store[k] = '0;
        endfunction

        function logic [CH_W-1:0] predict_byte(logic [FILT_W-1:0] kind, logic [CH_W-1:0] a,
                                               logic [CH_W-1:0] b, logic [CH_W-1:0] c);
            int pa;
            int pb;
            int pc;
            pa = int'(b) - int'(c);
            pb = int'(a) - int'(c);
            pc = int'(a) + int'(b) - 2 * int'(c);
            pa = (pa < 0) ? -pa : pa;
            pb = (pb < 0) ? -pb : pb;
            pc = (pc < 0) ? -pc : pc;
            case (kind)
                FILT_NONE: return '0;
                FILT_SUB:  return a;
                FILT_UP:   return b;
                FILT_AVG:  return CH_W'((int'(a) + int'(b)) >> 1);
                default:
                begin
                    if (pa <= pb && pa <= pc)
                        return a;
                    if (pb <= pc)
                        return b;
                    return c;
                end
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] d, logic [USER_W-1:0] u);
            int unsigned      eff_width;
            int unsigned      col;
            int               ch;
            bit               first_col;
            logic [PIX_W-1:0] above;
            logic [PIX_W-1:0] lft;
            logic [PIX_W-1:0] ul;
            logic [PIX_W-1:0] res;
            if (u[FILT_W])
            begin
                column = 0;
                first_row = 1'b1;
            end
            eff_width = (width_reg == 0) ? 1 : ((width_reg > WIDTH_MAX) ? MAX_WIDTH : width_reg);
            col = (column >= MAX_WIDTH) ? MAX_WIDTH - 1 : column;
            first_col = (col == 0);
            if (first_col)
            begin
                line_filt = (u[FILT_W-1:0] > FILT_PAETH) ? FILT_PAETH : u[FILT_W-1:0];
                line_count++;
                filter_lines[line_filt]++;
            end
            above = first_row ? '0 : row_store[col];
            lft = first_col ? '0 : left_pix;
            ul = (first_col || first_row) ? '0 : upleft_pix;
            for (ch = 0; ch < NUM_CH; ch++)
                res[ch*CH_W +: CH_W] = d[ch*CH_W +: CH_W] - predict_byte(line_filt,
                    lft[ch*CH_W +: CH_W], above[ch*CH_W +: CH_W], ul[ch*CH_W +: CH_W]);
            if (!alpha_on)
                res[3*CH_W +: CH_W] = '0;
            pending_words.push_back({first_col, line_filt, res});
            row_store[col] = d;
            upleft_pix = above;
            left_pix = d;
            if (col + 1 >= eff_width)
            begin
                column = 0;
                first_row = 1'b0;
            end
            else
                column = col + 1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("tb: mismatch at word %0d: %s", words_checked, msg);
        endtask

        task check_word(logic [PIX_W-1:0] data, logic [USER_W-1:0] user);
            word_t exp_w;
            int    ch;
            string names [NUM_CH];
            names = '{"out_red", "out_green", "out_blue", "out_alpha"};
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word data %h user %h", data, user));
                return;
            end
            exp_w = pending_words.pop_front();
            words_checked++;
            for (ch = 0; ch < NUM_CH; ch++)
                if (data[ch*CH_W +: CH_W] !== exp_w.data[ch*CH_W +: CH_W])
                    report_mismatch($sformatf("%s got %h expected %h", names[ch],
                        data[ch*CH_W +: CH_W], exp_w.data[ch*CH_W +: CH_W]));
            if (user[FILT_W-1:0] !== exp_w.user[FILT_W-1:0])
                report_mismatch($sformatf("type_tag got %0d expected %0d",
                    user[FILT_W-1:0], exp_w.user[FILT_W-1:0]));
            if (user[FILT_W] !== exp_w.user[FILT_W])
                report_mismatch($sformatf("line_start got %b expected %b",
                    user[FILT_W], exp_w.user[FILT_W]));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIDTH_W-1:0]   cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata = '0;   // red, green, blue, alpha
    logic [USER_W-1:0]    s_tuser = '0;   // filter_type, frame_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PIX_W-1:0]     m_tdata;        // out_red, out_green, out_blue, out_alpha
    logic [USER_W-1:0]    m_tuser;        // type_tag, line_start

    int               send_idle = 7;
    int               recv_idle = 65;
    int               cycles = 0;
    int unsigned      cur_width = 640;
    logic [PIX_W-1:0] last_pix = '0;
    logic [CH_W-1:0]  corner_vals [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    int               phase_width [NUM_PHASES] = '{1, 5, 0, 17, 8191, 4096, 64, 7, 2, 13, 300};
    bit               phase_alpha [NUM_PHASES] = '{0, 1, 1, 0, 1, 0, 0, 1, 0, 1, 1};
    int               phase_items [NUM_PHASES] = '{120, 150, 80, 200, 250, 40, 250, 250,
                                                   150, 200, 200};
    bit               phase_pause [NUM_PHASES] = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

    filter_scoreboard board = new();

    png_scanline_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_words.size() != 0);
    endtask

    task automatic set_config(input logic [WIDTH_W-1:0] w, input bit a);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_ALPHA_ENABLE;
        cfg_data <= WIDTH_W'(a);
        @(posedge clk);
        cfg_we <= 1'b0;
        board.width_reg = w;
        board.alpha_on = a;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] d, input logic [USER_W-1:0] u);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= u;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_pixel(d, u);
        last_pix = d;
    endtask

    // mix of extremes, values close to the last pixel and plain random bytes
    function automatic logic [CH_W-1:0] pick_sample(logic [CH_W-1:0] near);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 40)
            return near + CH_W'($urandom_range(3)) - CH_W'($urandom_range(3));
        return CH_W'($urandom);
    endfunction

    task automatic run_phase(input int w, input bit a, input int n, input bit pause_mid);
        int unsigned       eff;
        int                k;
        int                ch;
        bit                fresh;
        logic [PIX_W-1:0]  d;
        logic [USER_W-1:0] u;
        eff = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        // a wider line needs a new frame so that no stale row entry is read
        fresh = (eff > cur_width) || ($urandom_range(1) == 1);
        set_config(WIDTH_W'(w), a);
        cur_width = eff;
        for (k = 0; k < n; k++)
        begin
            for (ch = 0; ch < NUM_CH; ch++)
                d[ch*CH_W +: CH_W] = pick_sample(last_pix[ch*CH_W +: CH_W]);
            u[FILT_W-1:0] = FILT_W'($urandom);
            u[FILT_W] = (k == 0 && fresh) || ($urandom_range(99) < 2);
            send_pixel(d, u);
            if ((pause_mid && k == n / 2) || $urandom_range(199) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [PIX_W-1:0]  d;
        logic [USER_W-1:0] u;
        int                i;
        int                ch;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // short lines, every filter code at a line start, frame restart mid-line
        set_config(WIDTH_W'(3), 1'b1);
        cur_width = 3;
        for (i = 0; i < 24; i++)
        begin
            for (ch = 0; ch < NUM_CH; ch++)
                d[ch*CH_W +: CH_W] = corner_vals[(i * 3 + ch) % 5];
            u[FILT_W-1:0] = FILT_W'(i / 3);
            u[FILT_W] = (i == 0) || (i == 13);
            send_pixel(d, u);
        end

        for (i = 0; i < NUM_PHASES; i++)
        begin
            if (i >= 7)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (i >= 4)
            begin
                send_idle = 65;
                recv_idle = 7;
            end
            run_phase(phase_width[i], phase_alpha[i], phase_items[i], phase_pause[i]);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("tb: %0d pixels checked in %0d lines over %0d settings, widths 1 to 4096",
                 board.words_checked, board.line_count, NUM_PHASES + 1);
        $display("tb: lines per filter none/sub/up/average/paeth %0d/%0d/%0d/%0d/%0d",
                 board.filter_lines[0], board.filter_lines[1], board.filter_lines[2],
                 board.filter_lines[3], board.filter_lines[4]);
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
